// File: src/ums_pkg.sv
// package for the ui markup stripper: widths, codes, result type, helpers
`timescale 1ns / 1ps
`default_nettype none

package ums_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int OUT_LENGTH_BITS = 16;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_PIPE   = 3'd1;
   localparam logic [2:0] MODE_HEX    = 3'd2;
   localparam logic [2:0] MODE_SKH    = 3'd3;
   localparam logic [2:0] MODE_SKH_P  = 3'd4;
   localparam logic [2:0] MODE_SKT    = 3'd5;
   localparam logic [2:0] MODE_SKT_P  = 3'd6;

   localparam logic [7:0] CHAR_PIPE    = 8'h7C;
   localparam logic [7:0] CHAR_N       = 8'h6E;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_R       = 8'h72;
   localparam logic [7:0] CHAR_C       = 8'h63;
   localparam logic [7:0] CHAR_H_LO    = 8'h68;
   localparam logic [7:0] CHAR_H_UP    = 8'h48;
   localparam logic [7:0] CHAR_T_LO    = 8'h74;
   localparam logic [7:0] CHAR_T_UP    = 8'h54;

   localparam logic [3:0] HEX_RUN_MAX = 4'd8;

   typedef struct packed {
      logic [7:0]                 out_byte;
      logic                       out_valid;
      logic                       out_last;
      logic [OUT_LENGTH_BITS-1:0] out_length;
   } result_type;

   function automatic logic is_hex(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) ||
             ((b >= 8'h61) && (b <= 8'h66)) ||
             ((b >= 8'h41) && (b <= 8'h46));
   endfunction

endpackage

`default_nettype wire

// File: src/ums_req_if.sv
// request channel: one text byte and its last flag
`timescale 1ns / 1ps
`default_nettype none

interface ums_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: src/ums_rsp_if.sv
// response channel: one output byte, flags and string length
`timescale 1ns / 1ps
`default_nettype none

interface ums_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [7:0]                          out_byte;
   logic                                out_valid;
   logic                                out_last;
   logic [ums_pkg::OUT_LENGTH_BITS-1:0] out_length;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output out_length, input ready);
   modport sink (input valid, input out_byte, input out_valid, input out_last,
                 input out_length, output ready);
endinterface

`default_nettype wire

// File: src/ui_markup_stripper_unit.sv
// top level of the ui markup stripper: parser, length counter, result queue
// a request's first result is registered in the result queue and presented once the
// entries ahead are taken; throughput: one request per cycle while ready is high;
//   a two-byte request holds ready low while the three-entry result queue drains
// ready is high while the result queue holds at most one entry
// reset is synchronous: parser state, length and queue clear, strip_enable goes to 1
`timescale 1ns / 1ps
`default_nettype none

module ui_markup_stripper_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data,
   ums_req_if.sink    req_chan,
   ums_rsp_if.source  rsp_chan
);

   localparam int QUEUE_DEPTH = 3;

   logic                          strip_enable_ff, strip_enable_in;
   logic [2:0]                    mode_ff, mode_in;
   logic [3:0]                    hex_ff, hex_in;
   logic [ums_pkg::LENGTH_BITS-1:0] total_ff, total_in;
   ums_pkg::result_type           queue_ff [QUEUE_DEPTH];
   ums_pkg::result_type           queue_in [QUEUE_DEPTH];
   logic [1:0]                    count_ff, count_in;

   logic                          accept;
   logic                          pop;
   logic [1:0]                    base;

   // parser outputs for the current request
   logic [7:0]                    byte0, byte1;
   logic [1:0]                    puts;
   logic [1:0]                    results;
   logic [2:0]                    mode_step;
   logic [3:0]                    hex_step;
   logic [3:0]                    hex_inc;
   logic [ums_pkg::LENGTH_BITS:0] total_sum;
   logic [ums_pkg::LENGTH_BITS-1:0] total_sat;
   ums_pkg::result_type           res0, res1;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready      = (count_ff <= 2'd1);
   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.out_byte   = queue_ff[0].out_byte;
   assign rsp_chan.out_valid  = queue_ff[0].out_valid;
   assign rsp_chan.out_last   = queue_ff[0].out_last;
   assign rsp_chan.out_length = queue_ff[0].out_length;

   assign strip_enable_in = csr_wr_en ? csr_wr_data : strip_enable_ff;

   // parse one byte
   always_comb begin
      byte0     = 8'h00;
      byte1     = 8'h00;
      puts      = 2'd0;
      mode_step = mode_ff;
      hex_step  = hex_ff;
      hex_inc   = hex_ff + 4'd1;
      if (!strip_enable_ff) begin
         if (mode_ff == ums_pkg::MODE_PIPE) begin
            byte0 = ums_pkg::CHAR_PIPE;
            byte1 = req_chan.in_byte;
            puts  = 2'd2;
         end else begin
            byte0 = req_chan.in_byte;
            puts  = 2'd1;
         end
         mode_step = ums_pkg::MODE_NORMAL;
         hex_step  = 4'd0;
      end else begin
         case (mode_ff)
            ums_pkg::MODE_PIPE: begin
               mode_step = ums_pkg::MODE_NORMAL;
               case (req_chan.in_byte)
                  ums_pkg::CHAR_PIPE: begin
                     byte0 = ums_pkg::CHAR_PIPE;
                     puts  = 2'd1;
                  end
                  ums_pkg::CHAR_N: begin
                     byte0 = ums_pkg::CHAR_NEWLINE;
                     puts  = 2'd1;
                  end
                  ums_pkg::CHAR_R, ums_pkg::CHAR_H_LO, ums_pkg::CHAR_T_LO: begin
                     puts = 2'd0;
                  end
                  ums_pkg::CHAR_C: begin
                     mode_step = ums_pkg::MODE_HEX;
                     hex_step  = 4'd0;
                  end
                  ums_pkg::CHAR_H_UP: begin
                     mode_step = ums_pkg::MODE_SKH;
                  end
                  ums_pkg::CHAR_T_UP: begin
                     mode_step = ums_pkg::MODE_SKT;
                  end
                  default: begin
                     byte0 = ums_pkg::CHAR_PIPE;
                     byte1 = req_chan.in_byte;
                     puts  = 2'd2;
                  end
               endcase
            end
            ums_pkg::MODE_HEX: begin
               if (ums_pkg::is_hex(req_chan.in_byte)) begin
                  if (hex_inc >= ums_pkg::HEX_RUN_MAX) begin
                     mode_step = ums_pkg::MODE_NORMAL;
                     hex_step  = 4'd0;
                  end else begin
                     hex_step = hex_inc;
                  end
               end else begin
                  hex_step = 4'd0;
                  if (req_chan.in_byte == ums_pkg::CHAR_PIPE) begin
                     mode_step = ums_pkg::MODE_PIPE;
                  end else begin
                     mode_step = ums_pkg::MODE_NORMAL;
                     byte0     = req_chan.in_byte;
                     puts      = 2'd1;
                  end
               end
            end
            ums_pkg::MODE_SKH, ums_pkg::MODE_SKH_P: begin
               if (mode_ff == ums_pkg::MODE_SKH_P && req_chan.in_byte == ums_pkg::CHAR_H_LO) begin
                  mode_step = ums_pkg::MODE_NORMAL;
               end else if (req_chan.in_byte == ums_pkg::CHAR_PIPE) begin
                  mode_step = ums_pkg::MODE_SKH_P;
               end else begin
                  mode_step = ums_pkg::MODE_SKH;
               end
            end
            ums_pkg::MODE_SKT, ums_pkg::MODE_SKT_P: begin
               if (mode_ff == ums_pkg::MODE_SKT_P && req_chan.in_byte == ums_pkg::CHAR_T_LO) begin
                  mode_step = ums_pkg::MODE_NORMAL;
               end else if (req_chan.in_byte == ums_pkg::CHAR_PIPE) begin
                  mode_step = ums_pkg::MODE_SKT_P;
               end else begin
                  mode_step = ums_pkg::MODE_SKT;
               end
            end
            default: begin
               if (req_chan.in_byte == ums_pkg::CHAR_PIPE) begin
                  mode_step = ums_pkg::MODE_PIPE;
               end else begin
                  mode_step = ums_pkg::MODE_NORMAL;
                  byte0     = req_chan.in_byte;
                  puts      = 2'd1;
               end
            end
         endcase
      end

      // trailing pipe on the last byte
      if (req_chan.in_last && mode_step == ums_pkg::MODE_PIPE) begin
         if (puts == 2'd0) begin
            byte0 = ums_pkg::CHAR_PIPE;
         end else begin
            byte1 = ums_pkg::CHAR_PIPE;
         end
         puts = puts + 2'd1;
      end
   end

   // saturating length count
   always_comb begin
      total_sum = {1'b0, total_ff} + (ums_pkg::LENGTH_BITS+1)'(puts);
      if (total_sum > {1'b0, {ums_pkg::LENGTH_BITS{1'b1}}}) begin
         total_sat = {ums_pkg::LENGTH_BITS{1'b1}};
      end else begin
         total_sat = total_sum[ums_pkg::LENGTH_BITS-1:0];
      end
   end

   // build result entries
   always_comb begin
      res0.out_byte   = byte0;
      res0.out_valid  = (puts != 2'd0);
      res0.out_last   = 1'b0;
      res0.out_length = '0;
      res1.out_byte   = byte1;
      res1.out_valid  = 1'b1;
      res1.out_last   = 1'b0;
      res1.out_length = '0;
      results         = puts;
      if (req_chan.in_last) begin
         if (puts == 2'd2) begin
            res1.out_last   = 1'b1;
            res1.out_length = ums_pkg::OUT_LENGTH_BITS'(total_sat);
         end else begin
            res0.out_last   = 1'b1;
            res0.out_length = ums_pkg::OUT_LENGTH_BITS'(total_sat);
            results         = 2'd1;
         end
      end
   end

   // next parser state
   always_comb begin
      mode_in  = mode_ff;
      hex_in   = hex_ff;
      total_in = total_ff;
      if (accept) begin
         if (req_chan.in_last) begin
            mode_in  = ums_pkg::MODE_NORMAL;
            hex_in   = 4'd0;
            total_in = '0;
         end else begin
            mode_in  = mode_step;
            hex_in   = hex_step;
            total_in = total_sat;
         end
      end
   end

   // result queue, entry 0 is the head
   always_comb begin
      base = count_ff - {1'b0, pop};
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i+1];
         end
      end
      if (accept) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (results != 2'd0 && 2'(i) == base) begin
               queue_in[i] = res0;
            end
            if (results == 2'd2 && 2'(i) == base + 2'd1) begin
               queue_in[i] = res1;
            end
         end
      end
      count_in = base + (accept ? results : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_enable_ff <= 1'b1;
         mode_ff         <= ums_pkg::MODE_NORMAL;
         hex_ff          <= 4'd0;
         total_ff        <= '0;
         count_ff        <= 2'd0;
      end else begin
         strip_enable_ff <= strip_enable_in;
         mode_ff         <= mode_in;
         hex_ff          <= hex_in;
         total_ff        <= total_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   // end of string clears parser state
   assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.in_last |=> mode_ff == ums_pkg::MODE_NORMAL && hex_ff == 4'd0 &&
                                     total_ff == '0)
      else $error("parser state not cleared after last request");

   // hex run never reaches its limit in state
   assert property (@(posedge clock) disable iff (reset)
      hex_ff < ums_pkg::HEX_RUN_MAX)
      else $error("hex count out of range");

   // an empty result is always the closing one
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_valid |-> rsp_chan.out_last)
      else $error("empty result not marked last");

   // length only rides on the closing result
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_last |-> rsp_chan.out_length == '0)
      else $error("length on non-final result");

   // pass-through requests always produce a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && !strip_enable_ff |=> rsp_chan.valid)
      else $error("pass-through request gave no result");

endmodule

`default_nettype wire

// File: test/ui_markup_stripper_unit_test.sv
// self-checking testbench for ui_markup_stripper_unit: directed table and random text
`timescale 1ns / 1ps

module ui_markup_stripper_unit_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int PHASES = 8;
   localparam logic [PHASES-1:0] STRIP_PLAN = 8'b1011_0101;

   typedef struct packed {
      logic [7:0]          text_byte;
      logic                is_last;
      logic                fixed;
      ums_pkg::result_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   ums_req_if req_bus ();
   ums_rsp_if rsp_bus ();

   ui_markup_stripper_unit DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // predictor state
   logic                            strip_on = 1'b1;
   logic [2:0]                      parse_state = ums_pkg::MODE_NORMAL;
   logic [3:0]                      hex_seen = '0;
   logic [ums_pkg::LENGTH_BITS-1:0] out_total = '0;
   ums_pkg::result_type             step_out [0:1];
   int                              step_count;

   ums_pkg::result_type awaited_output [$];
   logic [7:0]          text_buf [$];
   int                  mismatch_count = 0;
   int unsigned         cycle_count = 0;
   bit                  steady_sender = 1'b0;
   bit                  steady_receiver = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void add_char(input logic [7:0] c);
      text_buf = {text_buf, c};
   endfunction

   function automatic void expect_result(input ums_pkg::result_type r);
      awaited_output = {awaited_output, r};
   endfunction

   function automatic logic hex_char(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      return ((c >= 8'h30) && (c <= 8'h39)) || ((folded >= 8'h61) && (folded <= 8'h66));
   endfunction

   function automatic void emit_char(input logic [7:0] c);
      if (out_total != '1)
         out_total = out_total + 1'b1;
      step_out[step_count] = {c, 1'b1, 1'b0, 16'd0};
      step_count = step_count + 1;
   endfunction

   function automatic void take_plain(input logic [7:0] c);
      if (c == ums_pkg::CHAR_PIPE) begin
         parse_state = ums_pkg::MODE_PIPE;
      end else begin
         parse_state = ums_pkg::MODE_NORMAL;
         emit_char(c);
      end
   endfunction

   function automatic void take_escape(input logic [7:0] c);
      parse_state = ums_pkg::MODE_NORMAL;
      case (c)
         ums_pkg::CHAR_PIPE: emit_char(ums_pkg::CHAR_PIPE);
         ums_pkg::CHAR_N: emit_char(ums_pkg::CHAR_NEWLINE);
         ums_pkg::CHAR_R, ums_pkg::CHAR_H_LO, ums_pkg::CHAR_T_LO: ;
         ums_pkg::CHAR_C: begin
            parse_state = ums_pkg::MODE_HEX;
            hex_seen = '0;
         end
         ums_pkg::CHAR_H_UP: parse_state = ums_pkg::MODE_SKH;
         ums_pkg::CHAR_T_UP: parse_state = ums_pkg::MODE_SKT;
         default: begin
            emit_char(ums_pkg::CHAR_PIPE);
            emit_char(c);
         end
      endcase
   endfunction

   function automatic void skip_char(input logic [7:0] c, input logic [2:0] plain_state,
                                     input logic [2:0] seen_state, input logic [7:0] closer);
      if ((parse_state == seen_state) && (c == closer))
         parse_state = ums_pkg::MODE_NORMAL;
      else if (c == ums_pkg::CHAR_PIPE)
         parse_state = seen_state;
      else
         parse_state = plain_state;
   endfunction

   function automatic void strip_markup_step(input logic [7:0] c, input logic lst);
      step_count = 0;
      if (!strip_on) begin
         if (parse_state == ums_pkg::MODE_PIPE)
            emit_char(ums_pkg::CHAR_PIPE);
         parse_state = ums_pkg::MODE_NORMAL;
         hex_seen = '0;
         emit_char(c);
      end else begin
         case (parse_state)
            ums_pkg::MODE_PIPE: take_escape(c);
            ums_pkg::MODE_HEX: begin
               if (hex_char(c)) begin
                  hex_seen = hex_seen + 1'b1;
                  if (hex_seen >= ums_pkg::HEX_RUN_MAX) begin
                     parse_state = ums_pkg::MODE_NORMAL;
                     hex_seen = '0;
                  end
               end else begin
                  hex_seen = '0;
                  take_plain(c);
               end
            end
            ums_pkg::MODE_SKH, ums_pkg::MODE_SKH_P:
               skip_char(c, ums_pkg::MODE_SKH, ums_pkg::MODE_SKH_P, ums_pkg::CHAR_H_LO);
            ums_pkg::MODE_SKT, ums_pkg::MODE_SKT_P:
               skip_char(c, ums_pkg::MODE_SKT, ums_pkg::MODE_SKT_P, ums_pkg::CHAR_T_LO);
            default: take_plain(c);
         endcase
      end
      if (lst) begin
         if (parse_state == ums_pkg::MODE_PIPE)
            emit_char(ums_pkg::CHAR_PIPE);
         if (step_count == 0) begin
            step_out[0] = '0;
            step_count = 1;
         end
         step_out[step_count-1].out_last = 1'b1;
         step_out[step_count-1].out_length = out_total[ums_pkg::OUT_LENGTH_BITS-1:0];
         parse_state = ums_pkg::MODE_NORMAL;
         hex_seen = '0;
         out_total = '0;
      end
   endfunction

   function automatic script_row_type row_open(input logic [7:0] c, input logic lst);
      return {c, lst, 1'b0, ums_pkg::result_type'(0)};
   endfunction

   function automatic script_row_type row_fixed(input logic [7:0] c, input logic lst,
                                                input logic [7:0] ob, input logic ov,
                                                input logic ol, input logic [15:0] len);
      return {c, lst, 1'b1, ob, ov, ol, len};
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == ums_pkg::CHAR_PIPE);
      return c;
   endfunction

   function automatic logic [7:0] random_hex();
      int unsigned k;
      k = $urandom_range(0, 21);
      if (k < 10)
         return 8'(8'h30 + k);
      else if (k < 16)
         return 8'(8'h61 + k - 10);
      else
         return 8'(8'h41 + k - 16);
   endfunction

   function automatic void skip_run(input logic [7:0] opener, input logic [7:0] closer);
      logic [7:0] c;
      add_char(ums_pkg::CHAR_PIPE);
      add_char(opener);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 4))
            0: c = ums_pkg::CHAR_PIPE;
            1: c = closer;
            2: c = opener;
            default: c = 8'($urandom_range(0, 255));
         endcase
         add_char(c);
      end
      if ($urandom_range(0, 7) != 0) begin
         add_char(ums_pkg::CHAR_PIPE);
         add_char(closer);
      end
   endfunction

   function automatic void add_token();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 11))
         0, 1, 2, 3: add_char(plain_char());
         4: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(ums_pkg::CHAR_PIPE);
         end
         5: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(ums_pkg::CHAR_N);
         end
         6: begin
            add_char(ums_pkg::CHAR_PIPE);
            case ($urandom_range(0, 2))
               0: add_char(ums_pkg::CHAR_R);
               1: add_char(ums_pkg::CHAR_H_LO);
               default: add_char(ums_pkg::CHAR_T_LO);
            endcase
         end
         7: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(ums_pkg::CHAR_C);
            repeat ($urandom_range(0, 10)) add_char(random_hex());
         end
         8: skip_run(ums_pkg::CHAR_H_UP, ums_pkg::CHAR_H_LO);
         9: skip_run(ums_pkg::CHAR_T_UP, ums_pkg::CHAR_T_LO);
         10: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(c);
         end
         default: add_char(c);
      endcase
   endfunction

   function automatic void build_string();
      int cut;
      text_buf.delete();
      repeat ($urandom_range(1, 12)) add_token();
      // broken string: cut off mid-sequence
      if (($urandom_range(0, 15) == 0) && (text_buf.size() > 1)) begin
         cut = $urandom_range(1, text_buf.size() - 1);
         while (text_buf.size() > cut) text_buf.delete(text_buf.size() - 1);
      end
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic lst, input logic fixed,
                            input ums_pkg::result_type want);
      int unsigned gap;
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= c;
      req_bus.in_last <= lst;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      strip_markup_step(c, lst);
      if (fixed)
         expect_result(want);
      else
         for (int i = 0; i < step_count; i++) expect_result(step_out[i]);
   endtask

   task automatic send_text(input logic close);
      for (int i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], close && (i == text_buf.size() - 1), 1'b0,
                   ums_pkg::result_type'(0));
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_output.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_strip(input logic value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      strip_on = value;
   endtask

   task automatic send_prefix(input int kind);
      text_buf.delete();
      case (kind)
         0: add_char(ums_pkg::CHAR_PIPE);
         1: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(ums_pkg::CHAR_C);
            repeat ($urandom_range(0, 3)) add_char(random_hex());
         end
         2, 3: begin
            add_char(ums_pkg::CHAR_PIPE);
            add_char(kind == 2 ? ums_pkg::CHAR_H_UP : ums_pkg::CHAR_T_UP);
            if ($urandom_range(0, 1) != 0)
               add_char(ums_pkg::CHAR_PIPE);
         end
         default: ;
      endcase
      send_text(1'b0);
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // response side
   initial begin
      int unsigned stall;
      ums_pkg::result_type got;
      ums_pkg::result_type want;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = steady_receiver ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
         got = {rsp_bus.out_byte, rsp_bus.out_valid, rsp_bus.out_last, rsp_bus.out_length};
         if (awaited_output.size() == 0) begin
            $display("%0t: unexpected response expected none actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = awaited_output.pop_front();
            check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            check_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
            check_field("out_last", 16'(want.out_last), 16'(got.out_last));
            check_field("out_length", want.out_length, got.out_length);
         end
      end
   end

   // request side
   initial begin
      script_row_type script [0:25];
      int phase_items;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.in_byte <= '0;
      req_bus.in_last <= 1'b0;

      script = '{
         row_open(ums_pkg::CHAR_PIPE, 1'b0), row_open(ums_pkg::CHAR_N, 1'b0),
         row_open(ums_pkg::CHAR_PIPE, 1'b0), row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_open(ums_pkg::CHAR_PIPE, 1'b0), row_open(ums_pkg::CHAR_R, 1'b0),
         row_open(ums_pkg::CHAR_PIPE, 1'b0), row_open(ums_pkg::CHAR_C, 1'b0),
         row_open(8'h61, 1'b0), row_open(8'h47, 1'b0),
         row_open(ums_pkg::CHAR_PIPE, 1'b0), row_open(ums_pkg::CHAR_H_UP, 1'b0),
         row_open(8'h78, 1'b0), row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_open(ums_pkg::CHAR_H_LO, 1'b0), row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_open(8'h71, 1'b0), row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_open(ums_pkg::CHAR_T_UP, 1'b0), row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_open(ums_pkg::CHAR_T_LO, 1'b1),
         row_fixed(ums_pkg::CHAR_PIPE, 1'b1, ums_pkg::CHAR_PIPE, 1'b1, 1'b1, 16'd1),
         row_fixed(8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 16'd1),
         row_fixed(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 16'd1),
         row_open(ums_pkg::CHAR_PIPE, 1'b0),
         row_fixed(ums_pkg::CHAR_H_UP, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_strip(1'b1);
      foreach (script[i])
         send_byte(script[i].text_byte, script[i].is_last, script[i].fixed, script[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         // leave a sequence open across the register write (kind 4 sends nothing)
         if (phase != 0)
            send_prefix(phase == 1 ? 0 : $urandom_range(0, 4));
         write_strip(STRIP_PLAN[phase]);
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            steady_sender = ($urandom_range(0, 5) == 0);
            steady_receiver = ($urandom_range(0, 5) == 0);
            build_string();
            send_text(1'b1);
            phase_items += text_buf.size();
         end
      end
      steady_sender = 1'b0;
      steady_receiver = 1'b0;

      settle();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
